### hw/rtl/tmcg_pkg.sv
`timescale 1ns / 1ps

package tmcg_pkg;

	// Command codes of an input word.
	localparam logic [2:0] CMD_TICK   = 3'd0;
	localparam logic [2:0] CMD_PLAY   = 3'd1;
	localparam logic [2:0] CMD_RECORD = 3'd2;
	localparam logic [2:0] CMD_STOP   = 3'd3;
	localparam logic [2:0] CMD_LOAD   = 3'd4;

	// Configuration register indexes.
	localparam logic [2:0] REG_FRAMES_PER_BEAT = 3'd0;
	localparam logic [2:0] REG_BEATS_PER_BAR   = 3'd1;
	localparam logic [2:0] REG_CLICK_LENGTH    = 3'd2;
	localparam logic [2:0] REG_METRO_ENABLE    = 3'd3;
	localparam logic [2:0] REG_METRO_GAIN      = 3'd4;

	// Transport states.
	localparam logic [1:0] TS_STOPPED   = 2'd0;
	localparam logic [1:0] TS_PLAYING   = 2'd1;
	localparam logic [1:0] TS_COUNT_IN  = 2'd2;
	localparam logic [1:0] TS_RECORDING = 2'd3;

	// Configuration reset values.
	localparam logic [18:0] RST_FRAMES_PER_BEAT = 19'd24000;
	localparam logic [5:0]  RST_BEATS_PER_BAR   = 6'd4;
	localparam logic [14:0] RST_CLICK_LENGTH    = 15'd4800;
	localparam logic        RST_METRO_ENABLE    = 1'b1;
	localparam logic [15:0] RST_METRO_GAIN      = 16'd19661;

	// Unity gain in Q1.15.
	localparam logic [16:0] GAIN_UNITY = 17'd32768;

	typedef struct packed {
		logic [2:0]         cmd;
		logic signed [39:0] play_frame;
		logic [7:0]         lead_bars;
		logic               table_select;
		logic [13:0]        table_index;
		logic signed [15:0] table_word;
	} in_word_t;

	typedef struct packed {
		logic signed [15:0] click_sample;
		logic signed [39:0] position;
		logic [1:0]         transport_state;
	} out_word_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic bar_go;
		logic mul_go;
		logic mul_rec;
		logic div_start;
		logic div_pass_b;
		logic div_cap_a;
		logic commit;
	} ctl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic div_done;
	} dp_sts_t;

endpackage

### hw/rtl/tmcg_div.sv
`timescale 1ns / 1ps

module tmcg_div import tmcg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [39:0] dividend,
	input  logic [18:0] divisor,
	output logic        done,
	output logic [39:0] quotient,
	output logic [18:0] remainder
);

	localparam int STEPS = 40;

	logic [39:0] quo_q;
	logic [18:0] rem_q;
	logic [18:0] dsr_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [19:0] trial;
	logic        fits;

	// One quotient bit per cycle, restoring form.
	assign trial = {rem_q, quo_q[39]};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 6'd1;
			if (cnt_q == 6'(STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[38:0], fits};
			rem_q <= fits ? 19'(trial - {1'b0, dsr_q}) : trial[18:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

### hw/rtl/tmcg_dp.sv
`timescale 1ns / 1ps

module tmcg_dp import tmcg_pkg::*; #(
	parameter int CLICK_DEPTH       = 16384,
	parameter int MAX_BEATS_PER_BAR = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [18:0] cfg_data,
	input  in_word_t  cmd_word,
	input  ctl_cmd_t  ctl,
	output dp_sts_t   sts,
	output out_word_t res_word
);

	localparam int AW  = $clog2(CLICK_DEPTH);
	localparam int BW  = (MAX_BEATS_PER_BAR > 1) ? $clog2(MAX_BEATS_PER_BAR) : 1;
	localparam int BPW = $clog2(MAX_BEATS_PER_BAR + 1);
	localparam int BBW = 8 + BPW;

	// Configuration.
	logic [18:0] fpb_q;
	logic [5:0]  bpb_q;
	logic [14:0] click_len_q;
	logic        enable_q;
	logic [15:0] gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fpb_q       <= RST_FRAMES_PER_BEAT;
			bpb_q       <= RST_BEATS_PER_BAR;
			click_len_q <= RST_CLICK_LENGTH;
			enable_q    <= RST_METRO_ENABLE;
			gain_q      <= RST_METRO_GAIN;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FRAMES_PER_BEAT: fpb_q       <= cfg_data;
				REG_BEATS_PER_BAR:   bpb_q       <= cfg_data[5:0];
				REG_CLICK_LENGTH:    click_len_q <= cfg_data[14:0];
				REG_METRO_ENABLE:    enable_q    <= cfg_data[0];
				REG_METRO_GAIN:      gain_q      <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	logic [18:0]    fpb_eff;
	logic [7:0]     bpb_wide;
	logic [BPW-1:0] bpb_eff;
	logic [16:0]    gain_eff;

	always_comb begin
		fpb_eff = (fpb_q == '0) ? 19'd1 : fpb_q;
		if (bpb_q == '0) begin
			bpb_wide = 8'd1;
		end else if ({2'b00, bpb_q} > 8'(MAX_BEATS_PER_BAR)) begin
			bpb_wide = 8'(MAX_BEATS_PER_BAR);
		end else begin
			bpb_wide = {2'b00, bpb_q};
		end
		bpb_eff  = bpb_wide[BPW-1:0];
		gain_eff = ({1'b0, gain_q} > GAIN_UNITY) ? GAIN_UNITY : {1'b0, gain_q};
	end

	// Transport state.
	logic signed [39:0] pos_q;
	logic [18:0]        phase_q;
	logic [BW-1:0]      beat_q;
	logic [1:0]         run_q;

	// Captured item.
	in_word_t in_q;

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			in_q <= cmd_word;
		end
	end

	// Click tables.
	logic signed [15:0] down_mem [CLICK_DEPTH];
	logic signed [15:0] off_mem  [CLICK_DEPTH];
	logic signed [15:0] down_rd_q;
	logic signed [15:0] off_rd_q;
	logic [16:0]        wr_wide;
	logic               wr_ok;
	logic [AW-1:0]      wr_addr;
	logic [AW-1:0]      rd_addr;
	logic               wr_down;
	logic               wr_off;

	assign wr_wide = {3'b000, in_q.table_index};
	assign wr_ok   = ctl.commit && (in_q.cmd == CMD_LOAD) && (wr_wide < 17'(CLICK_DEPTH));
	assign wr_addr = wr_wide[AW-1:0];
	assign wr_down = wr_ok && in_q.table_select;
	assign wr_off  = wr_ok && !in_q.table_select;
	assign rd_addr = phase_q[AW-1:0];

	always_ff @(posedge clk) begin
		if (wr_down) begin
			down_mem[wr_addr] <= in_q.table_word;
		end
		down_rd_q <= down_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (wr_off) begin
			off_mem[wr_addr] <= in_q.table_word;
		end
		off_rd_q <= off_mem[rd_addr];
	end

	// Shared multiplier: click word times gain, or count-in beats times beat length.
	logic [BBW-1:0]     bars_q;
	logic signed [19:0] mul_a;
	logic signed [19:0] mul_b;
	logic signed [39:0] mul_q;
	logic signed [15:0] click_word;

	assign click_word = (beat_q == '0) ? down_rd_q : off_rd_q;

	always_comb begin
		if (ctl.mul_rec) begin
			mul_a = signed'(20'(bars_q));
			mul_b = signed'({1'b0, fpb_eff});
		end else begin
			mul_a = 20'(click_word);
			mul_b = signed'({3'b000, gain_eff});
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.bar_go) begin
			bars_q <= BBW'(in_q.lead_bars) * BBW'(bpb_eff);
		end
		if (ctl.mul_go) begin
			mul_q <= mul_a * mul_b;
		end
	end

	// Floor division for play: first the frame by the beat length, then the
	// beat count by the bar length, on one serial divider.
	logic               neg_x;
	logic [39:0]        abs_x;
	logic [39:0]        div_dividend;
	logic [18:0]        div_divisor;
	logic               div_done;
	logic [39:0]        div_quo;
	logic [18:0]        div_rem;
	logic [39:0]        quo_a_q;
	logic [18:0]        rem_a_q;
	logic               rem_a_nz;

	assign neg_x    = in_q.play_frame[39];
	assign abs_x    = neg_x ? 40'(-in_q.play_frame) : in_q.play_frame;
	assign rem_a_nz = (rem_a_q != '0);

	assign div_dividend = ctl.div_pass_b ? (quo_a_q + 40'(neg_x && rem_a_nz)) : abs_x;
	assign div_divisor  = ctl.div_pass_b ? 19'(bpb_eff) : fpb_eff;

	tmcg_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (ctl.div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	always_ff @(posedge clk) begin
		if (ctl.div_cap_a) begin
			quo_a_q <= div_quo;
			rem_a_q <= div_rem;
		end
	end

	assign sts.div_done = div_done;

	// Next state and result of the captured item.
	logic               hit;
	logic signed [39:0] rnd;
	logic signed [24:0] shr;
	logic signed [15:0] sat;
	logic signed [39:0] pos_inc;
	logic [7:0]         beat_w;
	logic [7:0]         beat_b;
	logic signed [39:0] nxt_pos;
	logic [18:0]        nxt_phase;
	logic [BW-1:0]      nxt_beat;
	logic [1:0]         nxt_run;
	logic signed [15:0] nxt_sample;

	always_comb begin
		hit = enable_q && ({1'b0, phase_q} < {5'b00000, click_len_q})
			&& ({1'b0, phase_q} < 20'(CLICK_DEPTH));
		rnd = mul_q + 40'sd16384;
		shr = rnd[39:15];
		if (shr > 25'sd32767) begin
			sat = 16'sh7FFF;
		end else if (shr < -25'sd32768) begin
			sat = 16'sh8000;
		end else begin
			sat = shr[15:0];
		end
		pos_inc = pos_q + 40'sd1;
		beat_w  = 8'(beat_q) + 8'd1;
		beat_b  = 8'(div_rem);

		nxt_pos    = pos_q;
		nxt_phase  = phase_q;
		nxt_beat   = beat_q;
		nxt_run    = run_q;
		nxt_sample = '0;
		unique case (in_q.cmd)
			CMD_TICK: begin
				if (run_q != TS_STOPPED) begin
					nxt_sample = hit ? sat : 16'sd0;
					nxt_pos    = pos_inc;
					if (({1'b0, phase_q} + 20'd1) >= {1'b0, fpb_eff}) begin
						nxt_phase = '0;
						nxt_beat  = (beat_w >= 8'(bpb_eff)) ? '0 : beat_w[BW-1:0];
					end else begin
						nxt_phase = phase_q + 19'd1;
					end
					if (run_q == TS_COUNT_IN && !pos_inc[39]) begin
						nxt_run = TS_RECORDING;
					end
				end
			end
			CMD_PLAY: begin
				nxt_pos   = in_q.play_frame;
				nxt_phase = (neg_x && rem_a_nz) ? (fpb_eff - rem_a_q) : rem_a_q;
				nxt_beat  = (neg_x && beat_b != '0)
					? BW'(8'(bpb_eff) - beat_b) : beat_b[BW-1:0];
				nxt_run   = TS_PLAYING;
			end
			CMD_RECORD: begin
				nxt_pos   = -mul_q;
				nxt_phase = '0;
				nxt_beat  = '0;
				nxt_run   = (mul_q != '0) ? TS_COUNT_IN : TS_RECORDING;
			end
			CMD_STOP: begin
				nxt_run = TS_STOPPED;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			phase_q <= '0;
			beat_q  <= '0;
			run_q   <= TS_STOPPED;
		end else if (ctl.commit) begin
			pos_q   <= nxt_pos;
			phase_q <= nxt_phase;
			beat_q  <= nxt_beat;
			run_q   <= nxt_run;
		end
	end

	out_word_t out_q;

	always_ff @(posedge clk) begin
		if (ctl.commit) begin
			out_q.click_sample    <= nxt_sample;
			out_q.position        <= nxt_pos;
			out_q.transport_state <= nxt_run;
		end
	end

	assign res_word = out_q;

endmodule

### hw/rtl/tmcg_ctrl.sv
`timescale 1ns / 1ps

module tmcg_ctrl import tmcg_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	input  logic [2:0] cmd_code,
	input  logic       res_stall,
	input  dp_sts_t    sts,
	output logic       cmd_stall,
	output logic       res_valid,
	output ctl_cmd_t   ctl
);

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_TICK_RD  = 4'd1;
	localparam logic [3:0] S_TICK_MUL = 4'd2;
	localparam logic [3:0] S_DIV_A0   = 4'd3;
	localparam logic [3:0] S_DIV_A1   = 4'd4;
	localparam logic [3:0] S_DIV_B0   = 4'd5;
	localparam logic [3:0] S_DIV_B1   = 4'd6;
	localparam logic [3:0] S_REC_A    = 4'd7;
	localparam logic [3:0] S_REC_B    = 4'd8;
	localparam logic [3:0] S_DONE     = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       out_valid_q;
	logic       slot_free;

	assign slot_free = !out_valid_q || !res_stall;
	assign cmd_stall = (state_q != S_IDLE);
	assign res_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					ctl.capture = 1'b1;
					unique case (cmd_code)
						CMD_TICK:   state_d = S_TICK_RD;
						CMD_PLAY:   state_d = S_DIV_A0;
						CMD_RECORD: state_d = S_REC_A;
						default:    state_d = S_DONE;
					endcase
				end
			end
			S_TICK_RD: begin
				state_d = S_TICK_MUL;
			end
			S_TICK_MUL: begin
				ctl.mul_go = 1'b1;
				state_d    = S_DONE;
			end
			S_DIV_A0: begin
				ctl.div_start = 1'b1;
				state_d       = S_DIV_A1;
			end
			S_DIV_A1: begin
				if (sts.div_done) begin
					ctl.div_cap_a = 1'b1;
					state_d       = S_DIV_B0;
				end
			end
			S_DIV_B0: begin
				ctl.div_start  = 1'b1;
				ctl.div_pass_b = 1'b1;
				state_d        = S_DIV_B1;
			end
			S_DIV_B1: begin
				if (sts.div_done) begin
					state_d = S_DONE;
				end
			end
			S_REC_A: begin
				ctl.bar_go = 1'b1;
				state_d    = S_REC_B;
			end
			S_REC_B: begin
				ctl.mul_go  = 1'b1;
				ctl.mul_rec = 1'b1;
				state_d     = S_DONE;
			end
			S_DONE: begin
				if (slot_free) begin
					ctl.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.commit) begin
				out_valid_q <= 1'b1;
			end else if (!res_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### hw/rtl/transport_metronome_click_generator_core.sv
`timescale 1ns / 1ps

// Metronome click generator on a signed 40-bit frame transport. Each command
// word gives exactly one result word holding the click sample, the position
// after the command and the transport state. The block works on one command
// word at a time: a tick steps through accept, click table read, gain
// multiply and commit; a record start through bars times beats, times the
// beat length and commit; stop and table loads go from accept to commit;
// and a play runs the bit-serial divider twice, once
// to split the start frame into beats and once to split the beat count into
// bars. The result sits in an output register, so a new command word can be
// taken while the previous result still waits on res_stall. The two click
// tables hold CLICK_DEPTH words each and have no reset; an entry must be
// loaded before a tick reads it. The user writes configuration through cfg_we,
// cfg_index and cfg_data only while no command word is in flight; the block itself does not enforce it.
module transport_metronome_click_generator_core import tmcg_pkg::*; #(
	parameter int CLICK_DEPTH       = 16384,
	parameter int MAX_BEATS_PER_BAR = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [18:0] cfg_data,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  in_word_t    cmd_word,
	output logic        res_valid,
	input  logic        res_stall,
	output out_word_t   res_word
);

	ctl_cmd_t ctl;
	dp_sts_t  sts;

	// The controller sequences each command; the datapath holds the transport
	// state, the configuration, the click tables and the arithmetic units.
	tmcg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_code  (cmd_word.cmd),
		.res_stall (res_stall),
		.sts       (sts),
		.cmd_stall (cmd_stall),
		.res_valid (res_valid),
		.ctl       (ctl)
	);

	tmcg_dp #(
		.CLICK_DEPTH       (CLICK_DEPTH),
		.MAX_BEATS_PER_BAR (MAX_BEATS_PER_BAR)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd_word  (cmd_word),
		.ctl       (ctl),
		.sts       (sts),
		.res_word  (res_word)
	);

`ifndef ASSERT_OFF
	// Only one command word is in work at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> cmd_stall)
		else $error("command word accepted while another is in work");

	// A commit never overwrites a result that is still held.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.commit |-> !(res_valid && res_stall))
		else $error("result word overwritten while stalled");

	// Every commit presents a result on the next cycle.
	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.commit |=> res_valid)
		else $error("committed result not presented");

	// The divider only finishes while a play command is in work.
	a_div_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_done |-> cmd_stall)
		else $error("divider finished with no command in work");
`endif

endmodule
